// ===== sv/nss_pkg.sv =====
// ----------------------------------------------------------------------------
// nss_pkg
// shared types, constants and helpers for the substring search block
// ----------------------------------------------------------------------------
package nss_pkg;

    // buffer depth of both text and pattern store
    localparam int MAX_LEN = 128;
    // length counters hold 0..MAX_LEN
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    // buffer address
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;

    typedef enum logic [1:0] {
        OP_TEXT   = 2'd0,
        OP_PAT    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_SEARCH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        t_opcode             opcode;
        logic [CHAR_W-1:0]   char_value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]    match_position;
        logic                found;
        logic                overflow;
    } t_out_item;

    // status from the search sequencer to the top level
    typedef struct packed {
        logic                busy;
        logic                res_valid;
        logic                found;
        logic [POS_W-1:0]    pos;
    } t_seq_stat;

    // low bits of a position, zero extended when the length is narrow
    function automatic logic [POS_W-1:0] to_pos(input logic [LEN_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[POS_W-1:0];
    endfunction

endpackage

// ===== sv/nss_buf.sv =====
// ----------------------------------------------------------------------------
// nss_buf
// byte buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module nss_buf
    import nss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [CHAR_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_mem [MAX_LEN];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/nss_seq.sv =====
// ----------------------------------------------------------------------------
// nss_seq
// search sequencer: walks start and offset, reads a byte pair then compares it, in separate cycles
// ----------------------------------------------------------------------------
module nss_seq
    import nss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LEN_W-1:0]  i_text_len,
    input  logic [LEN_W-1:0]  i_pat_len,
    input  logic [CHAR_W-1:0] i_text_byte,
    input  logic [CHAR_W-1:0] i_pat_byte,
    input  logic              i_out_free,
    output logic [ADDR_W-1:0] o_text_addr,
    output logic [ADDR_W-1:0] o_pat_addr,
    output t_seq_stat         o_stat
);

    t_seq_state       r_state, n_state;
    logic [LEN_W-1:0] r_s, n_s;
    logic [LEN_W-1:0] r_k, n_k;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_found, n_found;

    logic [LEN_W:0]   s_plus_k;
    logic [LEN_W:0]   s_plus_p;
    logic [LEN_W:0]   k_inc;
    logic             byte_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_found <= n_found;
    end

    always_comb begin
        s_plus_k = {1'b0, r_s} + {1'b0, r_k};
        s_plus_p = {1'b0, r_s} + {1'b0, i_pat_len};
        k_inc    = {1'b0, r_k} + (LEN_W+1)'(1);
        // the shared compare unit
        byte_eq  = (i_text_byte == i_pat_byte);

        o_text_addr = s_plus_k[ADDR_W-1:0];
        o_pat_addr  = r_k[ADDR_W-1:0];

        n_state = r_state;
        n_s     = r_s;
        n_k     = r_k;
        n_pos   = r_pos;
        n_found = r_found;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_pat_len == '0) begin
                        n_pos   = to_pos(LEN_W'(1));
                        n_found = 1'b1;
                        n_state = S_DONE;
                    end else if (i_pat_len > i_text_len) begin
                        n_pos   = '0;
                        n_found = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_s     = '0;
                        n_k     = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (byte_eq) begin
                    if (k_inc == {1'b0, i_pat_len}) begin
                        n_pos   = to_pos(r_s + LEN_W'(1));
                        n_found = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_k     = k_inc[LEN_W-1:0];
                        n_state = S_READ;
                    end
                end else if (s_plus_p == {1'b0, i_text_len}) begin
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_s     = r_s + LEN_W'(1);
                    n_k     = '0;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_stat.busy      = (r_state != S_IDLE);
        o_stat.res_valid = (r_state == S_DONE);
        o_stat.found     = r_found;
        o_stat.pos       = r_pos;
    end

`ifndef SYNTHESIS
    // a new search only arrives while the sequencer is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("search started while sequencer busy");

    // compares never reach past the loaded text
    a_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (s_plus_k < {1'b0, i_text_len}))
        else $error("text read beyond its length");

    // offset stays inside the pattern
    a_in_pat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < i_pat_len))
        else $error("pattern read beyond its length");

    // a result is held until the output register takes it
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_out_free) |=> (r_state == S_DONE && $stable(r_pos)))
        else $error("search result lost before hand-off");
`endif

endmodule

// ===== sv/naive_substring_search.sv =====
// ----------------------------------------------------------------------------
// naive_substring_search
// loads text and pattern bytes, runs a brute-force first-match search
// ----------------------------------------------------------------------------
// append and clear transactions: taken one per cycle while no search runs or waits, no result
// search: each byte compare in the sequencer is a registered buffer read,
//   then a compare; an empty or too long pattern goes straight to the result;
//   input stalls while the search runs and while its result waits
// result goes to an output register; a search ahead of a stalled result waits
// reset (synchronous, active low) clears lengths, overflow flag and sequencer;
//   buffer contents are not cleared
// ----------------------------------------------------------------------------
module naive_substring_search
    import nss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // length counters and overflow flag
    logic [LEN_W-1:0]  r_tlen, n_tlen;
    logic [LEN_W-1:0]  r_plen, n_plen;
    logic              r_dropped, n_dropped;

    // output register
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              in_acc;
    logic              out_free;
    logic              t_wr;
    logic              p_wr;
    logic              seq_start;

    logic [ADDR_W-1:0] text_rd_addr;
    logic [ADDR_W-1:0] pat_rd_addr;
    logic [CHAR_W-1:0] text_byte;
    logic [CHAR_W-1:0] pat_byte;
    t_seq_stat         seq_stat;

    // text store
    nss_buf u_text_buf (
        .i_clk     (i_clk),
        .i_wr_en   (t_wr),
        .i_wr_addr (r_tlen[ADDR_W-1:0]),
        .i_wr_data (i_in_data.char_value),
        .i_rd_addr (text_rd_addr),
        .o_rd_data (text_byte)
    );

    // pattern store
    nss_buf u_pat_buf (
        .i_clk     (i_clk),
        .i_wr_en   (p_wr),
        .i_wr_addr (r_plen[ADDR_W-1:0]),
        .i_wr_data (i_in_data.char_value),
        .i_rd_addr (pat_rd_addr),
        .o_rd_data (pat_byte)
    );

    // compare sequencer
    nss_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (seq_start),
        .i_text_len  (r_tlen),
        .i_pat_len   (r_plen),
        .i_text_byte (text_byte),
        .i_pat_byte  (pat_byte),
        .i_out_free  (out_free),
        .o_text_addr (text_rd_addr),
        .o_pat_addr  (pat_rd_addr),
        .o_stat      (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen      <= '0;
            r_plen      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tlen      <= n_tlen;
            r_plen      <= n_plen;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_comb begin
        // input held off while a search is running or its result waits
        o_in_stall = seq_stat.busy;
        in_acc     = i_in_valid && !o_in_stall;
        // output register free when empty or drained this cycle
        out_free   = !r_out_valid || !i_out_stall;

        n_tlen      = r_tlen;
        n_plen      = r_plen;
        n_dropped   = r_dropped;
        t_wr        = 1'b0;
        p_wr        = 1'b0;
        seq_start   = 1'b0;

        if (in_acc) begin
            case (i_in_data.opcode)
                OP_TEXT: begin
                    // full buffer drops the byte and flags it
                    if (r_tlen != LEN_W'(MAX_LEN)) begin
                        t_wr   = 1'b1;
                        n_tlen = r_tlen + LEN_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                OP_PAT: begin
                    if (r_plen != LEN_W'(MAX_LEN)) begin
                        p_wr   = 1'b1;
                        n_plen = r_plen + LEN_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_tlen    = '0;
                    n_plen    = '0;
                    n_dropped = 1'b0;
                end
                OP_SEARCH: begin
                    seq_start = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // load a finished search into the output register
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (seq_stat.res_valid && out_free) begin
            n_out_valid                = 1'b1;
            n_out_data.match_position  = seq_stat.pos;
            n_out_data.found           = seq_stat.found;
            n_out_data.overflow        = r_dropped;
        end

        o_out_valid = r_out_valid;
        o_out_data  = r_out_data;
    end

`ifndef SYNTHESIS
    // lengths never pass the buffer depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tlen <= LEN_W'(MAX_LEN)) && (r_plen <= LEN_W'(MAX_LEN)))
        else $error("buffer length beyond depth");

    // buffers and lengths stay put during a search
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_stat.busy |=> ($stable(r_tlen) && $stable(r_plen) && $stable(r_dropped)))
        else $error("buffer state changed during search");

    // a reported match position is never zero for lengths that fit the field
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_stat.res_valid && seq_stat.found && (MAX_LEN < 256)) |-> (seq_stat.pos != '0))
        else $error("match found with position zero");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the brute-force substring search block
// ----------------------------------------------------------------------------
// directed transactions cover empty buffers, too long patterns, partial
// matches, overlapping and last-position matches, and dropped bytes on full
// buffers; random load/search sequences follow under several idle and stall
// mixes. a local model of both buffers predicts every search result
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nss_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    naive_substring_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // chance per cycle, in percent, of a sender gap and of a receiver stall
    int idle_pct  = 0;
    int stall_pct = 0;
    int n_errors  = 0;
    int n_sent    = 0;

    // search results still owed by the block, oldest first
    t_out_item pending_results[$];

    // mirror of the block's buffers
    logic [CHAR_W-1:0] text_mem [MAX_LEN];
    logic [CHAR_W-1:0] pat_mem  [MAX_LEN];
    int text_len = 0;
    int pat_len  = 0;
    bit dropped  = 1'b0;

    // 1-based start of the first occurrence, 0 when none
    function automatic int first_occurrence();
        int s;
        int k;
        if (pat_len == 0)
            return 1;
        if (pat_len > text_len)
            return 0;
        for (s = 0; s + pat_len <= text_len; s++) begin
            for (k = 0; k < pat_len; k++)
                if (text_mem[s + k] != pat_mem[k])
                    break;
            if (k == pat_len)
                return s + 1;
        end
        return 0;
    endfunction

    // update the mirror for one accepted transaction, queue a search result
    function automatic void track_item(t_in_item item);
        int        pos;
        t_out_item res;
        case (item.opcode)
            OP_TEXT: begin
                if (text_len < MAX_LEN) begin
                    text_mem[text_len] = item.char_value;
                    text_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            OP_PAT: begin
                if (pat_len < MAX_LEN) begin
                    pat_mem[pat_len] = item.char_value;
                    pat_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            OP_CLEAR: begin
                text_len = 0;
                pat_len  = 0;
                dropped  = 1'b0;
            end
            OP_SEARCH: begin
                pos                = first_occurrence();
                res.match_position = pos[POS_W-1:0];
                res.found          = (pos != 0);
                res.overflow       = dropped;
                pending_results.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    // one input transaction; valid stays high into the next call unless
    // a gap is drawn, so it is never lowered and raised in the same step
    task automatic send_item(t_opcode op, logic [CHAR_W-1:0] ch);
        t_in_item item;
        item.opcode     = op;
        item.char_value = ch;
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        // payload held until the block stops stalling
        while (o_in_stall)
            @(posedge i_clk);
        track_item(item);
        n_sent++;
    endtask

    // hold the sender off until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: check each accepted transaction, then pick the next stall
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: match_position %0d found %0b overflow %0b",
                           o_out_data.match_position, o_out_data.found,
                           o_out_data.overflow);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.match_position !== want.match_position) begin
                        $error("match_position: expected %0d, actual %0d",
                               want.match_position, o_out_data.match_position);
                        n_errors++;
                    end
                    if (o_out_data.found !== want.found) begin
                        $error("found: expected %0b, actual %0b",
                               want.found, o_out_data.found);
                        n_errors++;
                    end
                    if (o_out_data.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, o_out_data.overflow);
                        n_errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // search straight out of reset: both buffers empty, empty pattern hits at 1
    task automatic test_reset_state();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(OP_SEARCH, 8'($urandom));
    endtask

    // too long pattern, single byte mismatch, extreme byte values, empty
    // pattern over a filled text
    task automatic test_edge_cases();
        send_item(OP_PAT, 8'h00);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_TEXT, 8'h00);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_CLEAR, 8'($urandom));
        send_item(OP_TEXT, 8'h80);
        send_item(OP_TEXT, 8'h01);
        send_item(OP_SEARCH, 8'($urandom));
    endtask

    // back-up after a partial match, match ending on the last byte,
    // overlapping occurrences, pattern equal to the whole text
    task automatic test_first_match();
        send_item(OP_CLEAR, 8'($urandom));
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'hAA);
        send_item(OP_TEXT, 8'h55);
        send_item(OP_TEXT, 8'hAA);
        send_item(OP_TEXT, 8'hC3);
        send_item(OP_PAT, 8'h55);
        send_item(OP_PAT, 8'hAA);
        send_item(OP_PAT, 8'hC3);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_CLEAR, 8'($urandom));
        repeat (3) send_item(OP_TEXT, 8'h3C);
        repeat (2) send_item(OP_PAT, 8'h3C);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_PAT, 8'h3C);
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_PAT, 8'h3C);
        send_item(OP_SEARCH, 8'($urandom));
    endtask

    // full buffers, dropped bytes, last possible position, clear of the flag
    task automatic test_overflow();
        idle_pct  = 19;
        stall_pct = 19;
        // match at the highest position, extra text byte dropped
        send_item(OP_CLEAR, 8'($urandom));
        repeat (MAX_LEN - 1) send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_TEXT, 8'h5A);
        send_item(OP_PAT, 8'hFF);
        send_item(OP_SEARCH, 8'($urandom));
        // pattern filled to the full text length, then one byte past it
        repeat (MAX_LEN - 1) send_item(OP_PAT, 8'($urandom));
        send_item(OP_SEARCH, 8'($urandom));
        send_item(OP_PAT, 8'($urandom));
        send_item(OP_SEARCH, 8'($urandom));
        // clear drops the flag
        send_item(OP_CLEAR, 8'($urandom));
        send_item(OP_SEARCH, 8'($urandom));
        drain_results();
    endtask

    // one random case: mostly clear, load text and pattern interleaved,
    // search; sometimes plain noise or growth without a clear
    task automatic random_sequence();
        logic [CHAR_W-1:0] alpha [4];
        logic [CHAR_W-1:0] txt [$];
        logic [CHAR_W-1:0] pat [$];
        int kind;
        int n_alpha;
        int tlen;
        int plen;
        int cap;
        int s;
        int i;
        kind = $urandom_range(15);
        if (kind < 2) begin
            // noise: any opcode, any byte
            repeat ($urandom_range(8, 1))
                send_item(t_opcode'($urandom_range(3)), 8'($urandom));
        end else begin
            // a small alphabet of random bytes makes partial matches common
            n_alpha = $urandom_range(4, 1);
            foreach (alpha[j])
                alpha[j] = 8'($urandom);
            // rare long text, past the buffer end now and then
            tlen = (kind == 15) ? $urandom_range(MAX_LEN + 4, 96) : $urandom_range(16, 0);
            for (i = 0; i < tlen; i++)
                txt.push_back(alpha[$urandom_range(n_alpha - 1)]);
            case ($urandom_range(3))
                0: begin
                    // pattern cut from the text
                    if (tlen > 0) begin
                        s    = $urandom_range(tlen - 1);
                        cap  = (kind == 15) ? 64 : 8;
                        cap  = (tlen - s < cap) ? tlen - s : cap;
                        plen = $urandom_range(cap, 1);
                        for (i = 0; i < plen; i++)
                            pat.push_back(txt[s + i]);
                    end
                end
                1: begin
                    plen = $urandom_range(5, 1);
                    for (i = 0; i < plen; i++)
                        pat.push_back(alpha[$urandom_range(n_alpha - 1)]);
                end
                2: ; // empty pattern
                default: begin
                    // pattern longer than the text
                    plen = tlen + $urandom_range(3, 1);
                    for (i = 0; i < plen; i++)
                        pat.push_back(alpha[$urandom_range(n_alpha - 1)]);
                end
            endcase
            if ($urandom_range(7) != 0)
                send_item(OP_CLEAR, 8'($urandom));
            while (txt.size() != 0 || pat.size() != 0) begin
                if (pat.size() == 0 || (txt.size() != 0 && $urandom_range(1) == 1))
                    send_item(OP_TEXT, txt.pop_front());
                else
                    send_item(OP_PAT, pat.pop_front());
            end
            send_item(OP_SEARCH, 8'($urandom));
            // grow either buffer a little and search again
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(3, 1))
                    send_item($urandom_range(1) ? OP_TEXT : OP_PAT,
                              alpha[$urandom_range(n_alpha - 1)]);
                send_item(OP_SEARCH, 8'($urandom));
            end
        end
        // sender waits for the result path to empty now and then
        if ($urandom_range(7) == 0)
            drain_results();
    endtask

    task automatic run_phase(int idle, int stall, int n_items);
        int first;
        idle_pct  = idle;
        stall_pct = stall;
        first     = n_sent;
        while (n_sent - first < n_items)
            random_sequence();
        drain_results();
    endtask

    // random traffic under each idle/stall mix
    task automatic test_random_traffic();
        run_phase(0, 0, 85);
        run_phase(83, 0, 85);
        run_phase(0, 83, 85);
        run_phase(19, 19, 85);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_edge_cases();
        test_first_match();
        test_overflow();
        test_random_traffic();

        drain_results();
        // quiet tail: any stray result is flagged by the checker
        repeat (40) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
